// ===== hw/rtl/ssi_pkg.sv =====
// Shared types and constants for the segment intersection block.
// No dependencies; imported by every module of the block.
`default_nettype none
package ssi_pkg;
  localparam int unsigned CW  = 16;
  localparam int unsigned FB  = 16;
  localparam int unsigned DW  = 2 * CW + 3;
  localparam int unsigned NW  = CW + DW + 2;
  localparam int unsigned SW  = NW + FB;
  localparam int unsigned QB  = 32;
  localparam int unsigned HW  = SW - QB;
  localparam int unsigned LW  = (HW > DW) ? HW : DW;
  localparam int unsigned NS  = QB;
  localparam int unsigned QD  = 4;
  localparam int unsigned QAW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_CROSS   = 2'd1,
    CLS_OVERLAP = 2'd2,
    CLS_TOUCH   = 2'd3
  } hit_class_e;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [DW-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
  } div_part_t;

  typedef struct packed {
    hit_class_e    cls;
    logic [DW-1:0] dvs;
    div_part_t     x;
    div_part_t     y;
  } job_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           full;
    logic           empty;
  } q_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ssi_front.sv =====
// Front pipeline: products, classification and division setup, four stages.
// Depends on ssi_pkg.
`default_nettype none
module ssi_front import ssi_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [8*CW-1:0] s_data_i,
  output logic               job_valid_o,
  input  wire logic          job_ready_i,
  output job_t               job_o
);
  function automatic logic on_span(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                   input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                                   input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy);
    logic r;
    if (ax != bx) begin
      r = (ax <= cx && cx <= bx) || (ax >= cx && cx >= bx);
    end else begin
      r = (ay <= cy && cy <= by) || (ay >= cy && cy >= by);
    end
    return r;
  endfunction

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic signed [CW-1:0] c_in [8];
  logic signed [CW:0]   dycy, cydy, byay, ayby, ayd, cyay, cyby, ayc, axcx, bycy, aycy, bxcx;
  logic signed [DW-1:0] pd_d [4];
  logic signed [DW-1:0] pn_d [2];
  logic signed [DW-1:0] pt_d [3];
  logic signed [DW-1:0] pc_d [2];
  logic [3:0]           w_d;
  logic signed [DW-1:0] pd_q [4];
  logic signed [DW-1:0] pn_q [2];
  logic signed [DW-1:0] pt_q [3];
  logic signed [DW-1:0] pc_q [2];
  logic [3:0]           w_q;
  logic signed [CW-1:0] c_q [8];

  function automatic logic signed [CW:0] sub(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      c_in[i] = $signed(s_data_i[i*CW +: CW]);
    end
    dycy = sub(c_in[7], c_in[5]);
    cydy = sub(c_in[5], c_in[7]);
    byay = sub(c_in[3], c_in[1]);
    ayby = sub(c_in[1], c_in[3]);
    ayd  = sub(c_in[1], c_in[7]);
    cyay = sub(c_in[5], c_in[1]);
    cyby = sub(c_in[5], c_in[3]);
    ayc  = sub(c_in[1], c_in[5]);
    axcx = sub(c_in[0], c_in[4]);
    bycy = sub(c_in[3], c_in[5]);
    aycy = sub(c_in[1], c_in[5]);
    bxcx = sub(c_in[2], c_in[4]);
    pd_d[0] = c_in[0] * dycy;
    pd_d[1] = c_in[2] * cydy;
    pd_d[2] = c_in[6] * byay;
    pd_d[3] = c_in[4] * ayby;
    pn_d[0] = c_in[4] * ayd;
    pn_d[1] = c_in[6] * cyay;
    pt_d[0] = c_in[0] * cyby;
    pt_d[1] = c_in[2] * ayc;
    pt_d[2] = c_in[4] * byay;
    pc_d[0] = axcx * bycy;
    pc_d[1] = aycy * bxcx;
    w_d[0] = on_span(c_in[0], c_in[1], c_in[2], c_in[3], c_in[4], c_in[5]);
    w_d[1] = on_span(c_in[0], c_in[1], c_in[2], c_in[3], c_in[6], c_in[7]);
    w_d[2] = on_span(c_in[4], c_in[5], c_in[6], c_in[7], c_in[0], c_in[1]);
    w_d[3] = on_span(c_in[4], c_in[5], c_in[6], c_in[7], c_in[2], c_in[3]);
  end

  // stage 2
  logic signed [DW-1:0] den, ns, nt, crs, dabs, nsn, ntn;
  hit_class_e           cls2_d, cls2_q;
  logic [DW-1:0]        dvs2_d, dvs2_q;
  logic signed [DW-1:0] ns2_d, ns2_q;
  logic signed [CW-1:0] sx2_d, sy2_d, sx2_q, sy2_q;
  logic signed [CW:0]   dlx2_d, dly2_d, dlx2_q, dly2_q;

  always_comb begin
    den  = pd_q[0] + pd_q[1] + pd_q[2] + pd_q[3];
    ns   = pd_q[0] + pn_q[0] + pn_q[1];
    nt   = -(pt_q[0] + pt_q[1] + pt_q[2]);
    crs  = pc_q[0] - pc_q[1];
    dabs = den[DW-1] ? -den : den;
    nsn  = den[DW-1] ? -ns : ns;
    ntn  = den[DW-1] ? -nt : nt;
    dlx2_d = sub(c_q[2], c_q[0]);
    dly2_d = sub(c_q[3], c_q[1]);
    sx2_d  = c_q[0];
    sy2_d  = c_q[1];
    ns2_d  = nsn;
    dvs2_d = dabs;
    cls2_d = CLS_TOUCH;
    if (den == '0) begin
      dvs2_d = DW'(1);
      ns2_d  = '0;
      sx2_d  = '0;
      sy2_d  = '0;
      cls2_d = CLS_NONE;
      if (crs == '0) begin
        cls2_d = CLS_OVERLAP;
        priority if (w_q[0]) begin
          sx2_d = c_q[4]; sy2_d = c_q[5];
        end else if (w_q[1]) begin
          sx2_d = c_q[6]; sy2_d = c_q[7];
        end else if (w_q[2]) begin
          sx2_d = c_q[0]; sy2_d = c_q[1];
        end else if (w_q[3]) begin
          sx2_d = c_q[2]; sy2_d = c_q[3];
        end else begin
          cls2_d = CLS_NONE;
        end
      end
    end else if (nsn > 0 && nsn < dabs && ntn > 0 && ntn < dabs) begin
      cls2_d = CLS_CROSS;
    end else if (nsn < 0 || nsn > dabs || ntn < 0 || ntn > dabs) begin
      cls2_d = CLS_NONE;
    end
  end

  // stage 3
  logic signed [NW-1:0] tx0_q, tx1_q, ty0_q, ty1_q;
  hit_class_e           cls3_q;
  logic [DW-1:0]        dvs3_q;

  // stage 4
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        mx, my;
  logic [SW-1:0]        sxm, sym;
  logic [LW-1:0]        hx, hy, dv_ext;
  job_t                 job_d, job_q;

  always_comb begin
    nx  = tx0_q + tx1_q;
    ny  = ty0_q + ty1_q;
    mx  = nx[NW-1] ? NW'(-nx) : NW'(nx);
    my  = ny[NW-1] ? NW'(-ny) : NW'(ny);
    sxm = SW'(mx) << FB;
    sym = SW'(my) << FB;
    hx  = LW'(sxm[SW-1:QB]);
    hy  = LW'(sym[SW-1:QB]);
    dv_ext = LW'(dvs3_q);
    job_d.cls   = cls3_q;
    job_d.dvs   = dvs3_q;
    job_d.x.neg = nx[NW-1];
    job_d.x.ovf = hx >= dv_ext;
    job_d.x.rem = hx[DW-1:0];
    job_d.x.low = sxm[QB-1:0];
    job_d.x.quo = '0;
    job_d.y.neg = ny[NW-1];
    job_d.y.ovf = hy >= dv_ext;
    job_d.y.rem = hy[DW-1:0];
    job_d.y.low = sym[QB-1:0];
    job_d.y.quo = '0;
  end

  assign en4 = !v4_q || job_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_ready_o   = en1;
  assign job_valid_o = v4_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pd_q <= pd_d;
      pn_q <= pn_d;
      pt_q <= pt_d;
      pc_q <= pc_d;
      w_q  <= w_d;
      c_q  <= c_in;
    end
    if (en2) begin
      cls2_q <= cls2_d;
      dvs2_q <= dvs2_d;
      ns2_q  <= ns2_d;
      sx2_q  <= sx2_d;
      sy2_q  <= sy2_d;
      dlx2_q <= dlx2_d;
      dly2_q <= dly2_d;
    end
    if (en3) begin
      tx0_q  <= sx2_q * $signed({1'b0, dvs2_q});
      tx1_q  <= ns2_q * dlx2_q;
      ty0_q  <= sy2_q * $signed({1'b0, dvs2_q});
      ty1_q  <= ns2_q * dly2_q;
      cls3_q <= cls2_q;
      dvs3_q <= dvs2_q;
    end
    if (en4) job_q <= job_d;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ssi_queue.sv =====
// Short register queue of division jobs between front and back.
// Depends on ssi_pkg.
`default_nettype none
module ssi_queue import ssi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire job_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output job_t      out_data_o,
  output q_stat_t   stat_o
);
  job_t           mem_q [QD];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QCW-1:0] cnt_q;
  logic           push, pop, full, empty;

  assign full  = cnt_q == QCW'(QD);
  assign empty = cnt_q == '0;
  assign push  = in_valid_i && !full;
  assign pop   = out_ready_i && !empty;
  assign in_ready_o  = !full;
  assign out_valid_o = !empty;
  assign out_data_o  = mem_q[rptr_q];
  assign stat_o = '{count: cnt_q, full: full, empty: empty};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + QAW'(1);
      if (pop)  rptr_q <= rptr_q + QAW'(1);
      if (push && !pop) cnt_q <= cnt_q + QCW'(1);
      else if (pop && !push) cnt_q <= cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_data_i;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ssi_back.sv =====
// Back pipeline: two restoring dividers, one quotient bit per stage, then saturation.
// Depends on ssi_pkg.
`default_nettype none
module ssi_back import ssi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_i,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  output hit_class_e m_cls_o,
  output logic [QB-1:0] m_x_o,
  output logic [QB-1:0] m_y_o
);
  function automatic div_part_t step(input div_part_t p, input logic [DW-1:0] d);
    div_part_t  r;
    logic [DW:0] t, s;
    logic        ge;
    t  = {p.rem, p.low[QB-1]};
    s  = t - {1'b0, d};
    ge = t >= {1'b0, d};
    r  = p;
    r.rem = ge ? s[DW-1:0] : t[DW-1:0];
    r.low = p.low << 1;
    r.quo = {p.quo[QB-2:0], ge};
    return r;
  endfunction

  function automatic logic [QB-1:0] sat(input div_part_t p);
    logic [QB-1:0] r;
    if (p.neg) begin
      r = (p.ovf || p.quo > {1'b1, {(QB-1){1'b0}}}) ? {1'b1, {(QB-1){1'b0}}} : -p.quo;
    end else begin
      r = (p.ovf || p.quo[QB-1]) ? {1'b0, {(QB-1){1'b1}}} : p.quo;
    end
    return r;
  endfunction

  logic      v_q [NS];
  job_t      st_q [NS];
  job_t      st_d [NS];
  logic      en [NS+1];
  logic      out_v_q;
  hit_class_e out_cls_q;
  logic [QB-1:0] out_x_q, out_y_q;

  always_comb begin
    en[NS] = !out_v_q || m_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      st_d[k] = (k == 0) ? job_i : st_q[(k == 0) ? 0 : k - 1];
      st_d[k].x = step(st_d[k].x, st_d[k].dvs);
      st_d[k].y = step(st_d[k].y, st_d[k].dvs);
    end
  end

  assign job_ready_o = en[0];
  assign m_valid_o   = out_v_q;
  assign m_cls_o     = out_cls_q;
  assign m_x_o       = out_x_q;
  assign m_y_o       = out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? job_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end
      if (en[NS]) out_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
    if (en[NS]) begin
      out_cls_q <= st_q[NS-1].cls;
      out_x_q   <= sat(st_q[NS-1].x);
      out_y_q   <= sat(st_q[NS-1].y);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/segment_segment_intersection_top.sv =====
// Segment pair intersection top: front, job queue and divider back end.
// Depends on ssi_pkg, ssi_front, ssi_queue and ssi_back.
//
// Takes one pair of 2D segments per cycle while s_axis_tready is high and returns one result
// per pair, in order. The path runs through four front stages, the queue, 32 divider stages
// and the output register. Throughput is one pair per cycle when m_axis_tready does not
// stall the output. hit_class travels in tuser, the point in tdata.
`default_nettype none
module segment_segment_intersection_top import ssi_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
  // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
  input  wire logic [8*CW-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // point_x, point_y
  output logic [2*QB-1:0]    m_axis_tdata,
  // hit_class
  output logic [1:0]         m_axis_tuser
);
  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  job_t       fq_job, qb_job;
  q_stat_t    q_stat;
  hit_class_e cls;
  logic [QB-1:0] px, py;

  ssi_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_data_i(s_axis_tdata),
    .job_valid_o(fq_valid), .job_ready_i(fq_ready), .job_o(fq_job)
  );

  ssi_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fq_valid), .in_ready_o(fq_ready), .in_data_i(fq_job),
    .out_valid_o(qb_valid), .out_ready_i(qb_ready), .out_data_o(qb_job),
    .stat_o(q_stat)
  );

  ssi_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qb_valid), .job_ready_o(qb_ready), .job_i(qb_job),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_cls_o(cls), .m_x_o(px), .m_y_o(py)
  );

  assign m_axis_tdata = {py, px};
  assign m_axis_tuser = cls;

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCW'(QD))
    else $error("queue count beyond depth");

  a_q_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_stat.empty && qb_valid && !fq_ready)
    else $error("queue flags inconsistent");

  a_overlap_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == CLS_OVERLAP) |->
      ((px & QB'((64'd1 << FB) - 64'd1)) == '0 && (py & QB'((64'd1 << FB) - 64'd1)) == '0))
    else $error("overlap point off the integer grid");
endmodule
`default_nettype wire

// ===== dv/ssi_checker.sv =====
// Scoreboard for the segment intersection block: watches both streams,
// predicts each result from the input item and compares. Depends on ssi_pkg.
`timescale 1ns / 1ps
module ssi_checker import ssi_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  input  wire logic            s_axis_tready,
  input  wire logic [8*CW-1:0] s_axis_tdata,
  input  wire logic            m_axis_tvalid,
  input  wire logic            m_axis_tready,
  input  wire logic [2*QB-1:0] m_axis_tdata,
  input  wire logic [1:0]      m_axis_tuser,
  output int                   fail_count_o,
  output int                   pending_o
);
  typedef struct packed {
    hit_class_e  cls;
    logic [31:0] px;
    logic [31:0] py;
  } hit_t;

  hit_t pending_hits[$];

  function automatic logic [31:0] fix_point(longint num, longint den);
    logic signed [127:0] scaled;
    logic signed [127:0] quot;
    scaled = 128'(signed'(num));
    scaled = scaled <<< FB;
    quot = scaled / 128'(signed'(den));
    if (quot > 128'sd2147483647) return 32'h7fffffff;
    if (quot < -128'sd2147483648) return 32'h80000000;
    return quot[31:0];
  endfunction

  function automatic logic [31:0] fix_wide(logic signed [127:0] num, longint den);
    logic signed [127:0] quot;
    quot = (num <<< FB) / 128'(signed'(den));
    if (quot > 128'sd2147483647) return 32'h7fffffff;
    if (quot < -128'sd2147483648) return 32'h80000000;
    return quot[31:0];
  endfunction

  function automatic bit on_span(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
    if (ax != bx) return (ax <= cx && cx <= bx) || (ax >= cx && cx >= bx);
    return (ay <= cy && cy <= by) || (ay >= cy && cy >= by);
  endfunction

  function automatic hit_t predict_hit(logic [8*CW-1:0] d);
    longint ax, ay, bx, by, cx, cy, dx, dy, den, ns, nt, px, py;
    logic signed [127:0] wx, wy;
    hit_t h;
    ax = longint'($signed(d[0*CW +: CW])); ay = longint'($signed(d[1*CW +: CW]));
    bx = longint'($signed(d[2*CW +: CW])); by = longint'($signed(d[3*CW +: CW]));
    cx = longint'($signed(d[4*CW +: CW])); cy = longint'($signed(d[5*CW +: CW]));
    dx = longint'($signed(d[6*CW +: CW])); dy = longint'($signed(d[7*CW +: CW]));
    den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
    h = '{CLS_NONE, 32'd0, 32'd0};
    if (den == 0) begin
      if ((ax - cx) * (by - cy) - (ay - cy) * (bx - cx) == 0) begin
        h.cls = CLS_OVERLAP;
        if (on_span(ax, ay, bx, by, cx, cy)) begin px = cx; py = cy; end
        else if (on_span(ax, ay, bx, by, dx, dy)) begin px = dx; py = dy; end
        else if (on_span(cx, cy, dx, dy, ax, ay)) begin px = ax; py = ay; end
        else if (on_span(cx, cy, dx, dy, bx, by)) begin px = bx; py = by; end
        else h.cls = CLS_NONE;
        if (h.cls != CLS_NONE) begin
          h.px = fix_point(px, 1);
          h.py = fix_point(py, 1);
        end
      end
      return h;
    end
    ns = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
    nt = -(ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
    if (den < 0) begin den = -den; ns = -ns; nt = -nt; end
    if (ns > 0 && ns < den && nt > 0 && nt < den) h.cls = CLS_CROSS;
    else if (ns < 0 || ns > den || nt < 0 || nt > den) h.cls = CLS_NONE;
    else h.cls = CLS_TOUCH;
    wx = 128'(signed'(ax)) * 128'(signed'(den)) + 128'(signed'(ns)) * 128'(signed'(bx - ax));
    wy = 128'(signed'(ay)) * 128'(signed'(den)) + 128'(signed'(ns)) * 128'(signed'(by - ay));
    h.px = fix_wide(wx, den);
    h.py = fix_wide(wy, den);
    return h;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t want;
    int errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      if (s_axis_tvalid && s_axis_tready) pending_hits.push_back(predict_hit(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_hits.size() == 0) begin
          $error("unexpected result item");
          errs++;
        end else begin
          want = pending_hits.pop_front();
          if (m_axis_tuser !== want.cls) begin
            $error("hit_class expected %0d actual %0d", want.cls, m_axis_tuser);
            errs++;
          end
          if (m_axis_tdata[31:0] !== want.px) begin
            $error("point_x expected %h actual %h", want.px, m_axis_tdata[31:0]);
            errs++;
          end
          if (m_axis_tdata[63:32] !== want.py) begin
            $error("point_y expected %h actual %h", want.py, m_axis_tdata[63:32]);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= pending_hits.size();
    end
  end
endmodule

// ===== dv/testbench.sv =====
// Top of the segment intersection testbench: clock, reset, stimulus and verdict.
// Depends on ssi_pkg, segment_segment_intersection_top and ssi_checker.
`timescale 1ns / 1ps
module testbench import ssi_pkg::*; ();
  localparam int RandomPairs = 1600;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [8*CW-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [2*QB-1:0] m_axis_tdata;
  logic [1:0]      m_axis_tuser;
  int              fail_count;
  int              pending;
  bit              hold_off = 1'b0;

  typedef logic [8*CW-1:0] pair_t;
  pair_t pair_list[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_segment_intersection_top u_top (.*);

  ssi_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [CW-1:0] rand_coord(int span);
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 2 * span) - span);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return CW'($urandom_range(0, 8) - 4);
    endcase
  endfunction

  function automatic pair_t make_pair(int ax, int ay, int bx, int by,
                                      int cx, int cy, int dx, int dy);
    return {CW'(dy), CW'(dx), CW'(cy), CW'(cx), CW'(by), CW'(bx), CW'(ay), CW'(ax)};
  endfunction

  function automatic pair_t rand_pair();
    int ax, ay, bx, by, k;
    pair_t p;
    for (int i = 0; i < 8; i++) p[i*CW +: CW] = rand_coord(100);
    if ($urandom_range(0, 3) == 0) begin
      ax = $urandom_range(0, 40) - 20; ay = $urandom_range(0, 40) - 20;
      bx = $urandom_range(0, 10) - 5;  by = $urandom_range(0, 10) - 5;
      k = $urandom_range(0, 6) - 3;
      p = make_pair(ax, ay, ax + 2 * bx, ay + 2 * by, ax + k * bx, ay + k * by,
                    ax + (k + 2) * bx, ay + (k + 2) * by);
    end else if ($urandom_range(0, 4) == 0) begin
      p[4*CW +: CW] = p[0*CW +: CW];
      p[5*CW +: CW] = p[1*CW +: CW];
    end
    return p;
  endfunction

  initial begin
    pair_list.push_back(make_pair(0, 0, 4, 4, 0, 4, 4, 0));
    pair_list.push_back(make_pair(0, 0, 4, 4, 4, 4, 8, 0));
    pair_list.push_back(make_pair(0, 0, 4, 0, 2, 0, 6, 0));
    pair_list.push_back(make_pair(0, 0, 4, 0, 5, 0, 9, 0));
    pair_list.push_back(make_pair(0, 0, 4, 0, 0, 1, 4, 1));
    pair_list.push_back(make_pair(0, 0, 0, 4, 0, 2, 0, 9));
    pair_list.push_back(make_pair(0, 0, 1, 1, 5, 0, 6, -3));
    pair_list.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pair_list.push_back(make_pair(-2, 1, 6, 4, -6, 2, 4, 12));
    pair_list.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pair_list.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pair_list.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768));
    pair_list.push_back(make_pair(-32768, 0, -32767, 1, 32767, 0, 32766, 1));
    pair_list.push_back(make_pair(-32768, -32768, 32767, -32767, 32767, 32767, 32766, 32767));
    pair_list.push_back(make_pair(0, 0, 1, 0, 0, -32768, 1, 32767));
    pair_list.push_back(make_pair(2, 2, 6, 6, 0, 0, 9, 9));
    pair_list.push_back(make_pair(0, 0, 4, 4, 2, 2, 2, 2));
    pair_list.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    for (int i = 0; i < RandomPairs; i++) pair_list.push_back(rand_pair());
  end

  initial begin
    int gap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pair_list.size() > 0) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 30)) begin
        if (pair_list.size() == 0) break;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair_list.pop_front();
        @(posedge clk_i);
        while (!s_axis_tready) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if ((($urandom_range(0, 255) >> 5) & 1) == 1) m_axis_tready <= 1'b1;
    else m_axis_tready <= $urandom_range(0, 3) != 0;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
